// ===== rtl/mlr_pkg.sv =====
// Shared constants and types of the midpoint line rasterizer.
package mlr_pkg;

  // Coordinate width of every point and endpoint.
  localparam int unsigned COORD_BITS = 12;
  // Width of an endpoint difference, which needs one bit more than a coordinate.
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  // Width of the decision value and its increments.
  localparam int unsigned DEC_BITS   = COORD_BITS + 5;
  // Width of the ink value.
  localparam int unsigned INK_BITS   = 8;

  // Input word kinds.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } mlr_kind_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [INK_BITS-1:0]          ink_t;

endpackage

// ===== rtl/mlr_in_if.sv =====
// Input channel of the rasterizer: start and step words.
interface mlr_in_if;
  logic              valid;
  logic              ready;
  mlr_pkg::mlr_kind_e kind;
  mlr_pkg::coord_t   start_row;
  mlr_pkg::coord_t   start_col;
  mlr_pkg::coord_t   end_row;
  mlr_pkg::coord_t   end_col;
  mlr_pkg::ink_t     ink;

  modport source (
    output valid, kind, start_row, start_col, end_row, end_col, ink,
    input  ready
  );
  modport sink (
    input  valid, kind, start_row, start_col, end_row, end_col, ink,
    output ready
  );
endinterface

// ===== rtl/mlr_out_if.sv =====
// Output channel of the rasterizer: one pixel word per step.
interface mlr_out_if;
  logic            valid;
  logic            ready;
  mlr_pkg::coord_t pixel_row;
  mlr_pkg::coord_t pixel_col;
  mlr_pkg::ink_t   pixel_ink;
  logic            final_point;

  modport source (
    output valid, pixel_row, pixel_col, pixel_ink, final_point,
    input  ready
  );
  modport sink (
    input  valid, pixel_row, pixel_col, pixel_ink, final_point,
    output ready
  );
endinterface

// ===== rtl/midpoint_line_rasterizer.sv =====
// Top level of the midpoint line rasterizer.
//
// A start word latches two signed endpoints and an ink value and sets up the
// line; it produces no pixel word and replaces any line in progress. Every
// step word while a line is active produces one pixel word (row, column, ink)
// and flags the last point, after which the block goes idle; step words while
// idle produce nothing. The major axis is the row axis when the row span is
// strictly larger than the column span, else the column axis, and points run
// in the direction of a rising major coordinate. One word is accepted every
// clock unless the output stalls: the setup of a start word (endpoint differences,
// absolute spans, one compare and the initial decision) and the adds and compares
// of a step word are combinational in front of the line state registers and the
// pixel output register, so a pixel word is valid in the cycle after its step
// word is accepted. The output register lets the input advance while a pixel
// word waits, as long as the sink takes it in the same cycle; otherwise the input
// stalls until it does. Endpoints are not clipped.
module midpoint_line_rasterizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mlr_in_if.sink    line_i,
  mlr_out_if.source pixel_o
);

  // Line state.
  mlr_pkg::coord_t cur_row_q, cur_row_d;
  mlr_pkg::coord_t cur_col_q, cur_col_d;
  mlr_pkg::coord_t major_end_q, major_end_d;
  mlr_pkg::dec_t   decision_q, decision_d;
  mlr_pkg::dec_t   incr_straight_q, incr_straight_d;
  mlr_pkg::dec_t   incr_up_diag_q, incr_up_diag_d;
  mlr_pkg::dec_t   incr_down_diag_q, incr_down_diag_d;
  logic            major_is_second_q, major_is_second_d;
  logic            minor_descends_q, minor_descends_d;
  mlr_pkg::ink_t   held_ink_q, held_ink_d;
  logic            active_q, active_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  mlr_pkg::coord_t out_row_q, out_row_d;
  mlr_pkg::coord_t out_col_q, out_col_d;
  mlr_pkg::ink_t   out_ink_q, out_ink_d;
  logic            out_final_q, out_final_d;

  logic accept;

  // Setup signals.
  mlr_pkg::diff_t d_row, d_col, abs_row, abs_col, d_maj, d_min;
  mlr_pkg::dec_t  dmaj_x, dmin_x;
  logic           row_major, swap_ends;

  // Step signals.
  mlr_pkg::coord_t cur_major;
  logic            last_point;
  logic            dec_nonpos;

  // A new word is taken whenever the output register is empty or being drained.
  assign accept       = line_i.valid && line_i.ready;
  assign line_i.ready = !out_valid_q || pixel_o.ready;

  // Endpoint spans, major axis choice and direction of travel.
  always_comb begin
    d_row   = {line_i.end_row[mlr_pkg::COORD_BITS-1], line_i.end_row}
            - {line_i.start_row[mlr_pkg::COORD_BITS-1], line_i.start_row};
    d_col   = {line_i.end_col[mlr_pkg::COORD_BITS-1], line_i.end_col}
            - {line_i.start_col[mlr_pkg::COORD_BITS-1], line_i.start_col};
    abs_row = d_row[mlr_pkg::DIFF_BITS-1] ? -d_row : d_row;
    abs_col = d_col[mlr_pkg::DIFF_BITS-1] ? -d_col : d_col;
    row_major = abs_row > abs_col;
    if (row_major) begin
      swap_ends = d_row[mlr_pkg::DIFF_BITS-1];
      d_maj     = abs_row;
      d_min     = swap_ends ? -d_col : d_col;
    end else begin
      swap_ends = d_col[mlr_pkg::DIFF_BITS-1];
      d_maj     = abs_col;
      d_min     = swap_ends ? -d_row : d_row;
    end
    dmaj_x = {{(mlr_pkg::DEC_BITS-mlr_pkg::DIFF_BITS){d_maj[mlr_pkg::DIFF_BITS-1]}}, d_maj};
    dmin_x = {{(mlr_pkg::DEC_BITS-mlr_pkg::DIFF_BITS){d_min[mlr_pkg::DIFF_BITS-1]}}, d_min};
  end

  // Current point position along the major axis and the decision test.
  always_comb begin
    cur_major  = major_is_second_q ? cur_col_q : cur_row_q;
    last_point = !(cur_major < major_end_q);
    dec_nonpos = decision_q[mlr_pkg::DEC_BITS-1] || (decision_q == '0);
  end

  // Next line state and next output word.
  always_comb begin
    cur_row_d         = cur_row_q;
    cur_col_d         = cur_col_q;
    major_end_d       = major_end_q;
    decision_d        = decision_q;
    incr_straight_d   = incr_straight_q;
    incr_up_diag_d    = incr_up_diag_q;
    incr_down_diag_d  = incr_down_diag_q;
    major_is_second_d = major_is_second_q;
    minor_descends_d  = minor_descends_q;
    held_ink_d        = held_ink_q;
    active_d          = active_q;
    out_valid_d       = out_valid_q && !pixel_o.ready;
    out_row_d         = out_row_q;
    out_col_d         = out_col_q;
    out_ink_d         = out_ink_q;
    out_final_d       = out_final_q;

    if (accept) begin
      case (line_i.kind)
        mlr_pkg::KIND_START: begin
          major_is_second_d = !row_major;
          minor_descends_d  = d_min[mlr_pkg::DIFF_BITS-1];
          cur_row_d   = swap_ends ? line_i.end_row : line_i.start_row;
          cur_col_d   = swap_ends ? line_i.end_col : line_i.start_col;
          if (row_major) begin
            major_end_d = swap_ends ? line_i.start_row : line_i.end_row;
          end else begin
            major_end_d = swap_ends ? line_i.start_col : line_i.end_col;
          end
          decision_d  = d_min[mlr_pkg::DIFF_BITS-1] ? (dmin_x <<< 1) + dmaj_x
                                                    : (dmin_x <<< 1) - dmaj_x;
          incr_up_diag_d   = (dmin_x - dmaj_x) <<< 1;
          incr_straight_d  = dmin_x <<< 1;
          incr_down_diag_d = (dmin_x + dmaj_x) <<< 1;
          held_ink_d  = line_i.ink;
          active_d    = 1'b1;
          out_valid_d = 1'b0;
        end
        mlr_pkg::KIND_STEP: begin
          out_valid_d = active_q;
          if (active_q) begin
            out_row_d   = cur_row_q;
            out_col_d   = cur_col_q;
            out_ink_d   = held_ink_q;
            out_final_d = last_point;
            if (last_point) begin
              active_d = 1'b0;
            end else begin
              // Advance the major coordinate and, by the decision, the minor one.
              if (major_is_second_q) begin
                cur_col_d = cur_col_q + mlr_pkg::coord_t'(1);
              end else begin
                cur_row_d = cur_row_q + mlr_pkg::coord_t'(1);
              end
              if (!minor_descends_q) begin
                if (dec_nonpos) begin
                  decision_d = decision_q + incr_straight_q;
                end else begin
                  decision_d = decision_q + incr_up_diag_q;
                  if (major_is_second_q) begin
                    cur_row_d = cur_row_q + mlr_pkg::coord_t'(1);
                  end else begin
                    cur_col_d = cur_col_q + mlr_pkg::coord_t'(1);
                  end
                end
              end else begin
                if (dec_nonpos) begin
                  decision_d = decision_q + incr_down_diag_q;
                  if (major_is_second_q) begin
                    cur_row_d = cur_row_q - mlr_pkg::coord_t'(1);
                  end else begin
                    cur_col_d = cur_col_q - mlr_pkg::coord_t'(1);
                  end
                end else begin
                  decision_d = decision_q + incr_straight_q;
                end
              end
            end
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end
  end

  // Control and line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q         <= '0;
      cur_col_q         <= '0;
      major_end_q       <= '0;
      decision_q        <= '0;
      incr_straight_q   <= '0;
      incr_up_diag_q    <= '0;
      incr_down_diag_q  <= '0;
      major_is_second_q <= 1'b0;
      minor_descends_q  <= 1'b0;
      held_ink_q        <= '0;
      active_q          <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      cur_row_q         <= cur_row_d;
      cur_col_q         <= cur_col_d;
      major_end_q       <= major_end_d;
      decision_q        <= decision_d;
      incr_straight_q   <= incr_straight_d;
      incr_up_diag_q    <= incr_up_diag_d;
      incr_down_diag_q  <= incr_down_diag_d;
      major_is_second_q <= major_is_second_d;
      minor_descends_q  <= minor_descends_d;
      held_ink_q        <= held_ink_d;
      active_q          <= active_d;
      out_valid_q       <= out_valid_d;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_ink_q   <= out_ink_d;
    out_final_q <= out_final_d;
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_row   = out_row_q;
  assign pixel_o.pixel_col   = out_col_q;
  assign pixel_o.pixel_ink   = out_ink_q;
  assign pixel_o.final_point = out_final_q;

endmodule
